@@ rtl/bvlq_pkg.sv @@
// Battery voltage level qualifier: shared types and constants.
// Used by the channel interfaces and every module of the block; no dependencies.
package bvlq_pkg;

	localparam int MV_W       = 16;
	localparam int NEED_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Qualified battery status
	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_NORMAL  = 2'd1,
		ST_LOW     = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRITICAL_LEVEL = 3'd0,
		REG_TRIP_LEVEL     = 3'd1,
		REG_RECOVERY_LEVEL = 3'd2,
		REG_LOW_CONFIRM    = 3'd3,
		REG_VALID_CONFIRM  = 3'd4,
		REG_RECOV_CONFIRM  = 3'd5
	} cfg_idx_t;

	// Reset values of the configuration registers
	localparam logic [MV_W-1:0]   CRITICAL_LEVEL_RST = 16'd3300;
	localparam logic [MV_W-1:0]   TRIP_LEVEL_RST     = 16'd3500;
	localparam logic [MV_W-1:0]   RECOVERY_LEVEL_RST = 16'd3700;
	localparam logic [NEED_W-1:0] CONFIRM_RST        = 8'd3;

	// Configuration as seen by the qualifier core
	typedef struct packed {
		logic [MV_W-1:0]   critical_level_mv;
		logic [MV_W-1:0]   trip_level_mv;
		logic [MV_W-1:0]   recovery_level_mv;
		logic [NEED_W-1:0] low_confirm_needed;
		logic [NEED_W-1:0] valid_confirm_needed;
		logic [NEED_W-1:0] recovery_confirm_needed;
	} cfg_t;

endpackage

@@ rtl/bvlq_ifs.sv @@
// Battery voltage level qualifier: valid/ready channel interfaces.
// Depends on bvlq_pkg for field widths.

// Event channel: voltage sample or invalidate
interface bvlq_evt_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [bvlq_pkg::MV_W-1:0]   sample_mv;

	modport source(output valid, func, sample_mv, input ready);
	modport sink(input valid, func, sample_mv, output ready);
endinterface

// Result channel: status after each event
interface bvlq_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] battery_status;
	logic       is_low;

	modport source(output valid, battery_status, is_low, input ready);
	modport sink(input valid, battery_status, is_low, output ready);
endinterface

// Configuration write channel
interface bvlq_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bvlq_pkg::CFG_IDX_W-1:0]     index;
	logic [bvlq_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/bvlq_cfg_regs.sv @@
// Battery voltage level qualifier: configuration register file.
// Depends on bvlq_pkg (cfg_t, register indexes, reset values) and bvlq_cfg_if.
module bvlq_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	bvlq_cfg_if.sink        cfg,
	output bvlq_pkg::cfg_t  cfg_q
);

	// Always take writes
	assign cfg.ready = 1'b1;

	// Update the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_level_mv       <= bvlq_pkg::CRITICAL_LEVEL_RST;
			cfg_q.trip_level_mv           <= bvlq_pkg::TRIP_LEVEL_RST;
			cfg_q.recovery_level_mv       <= bvlq_pkg::RECOVERY_LEVEL_RST;
			cfg_q.low_confirm_needed      <= bvlq_pkg::CONFIRM_RST;
			cfg_q.valid_confirm_needed    <= bvlq_pkg::CONFIRM_RST;
			cfg_q.recovery_confirm_needed <= bvlq_pkg::CONFIRM_RST;
		end else if (cfg.valid) begin
			unique case (bvlq_pkg::cfg_idx_t'(cfg.index))
				bvlq_pkg::REG_CRITICAL_LEVEL: cfg_q.critical_level_mv <= cfg.data;
				bvlq_pkg::REG_TRIP_LEVEL:     cfg_q.trip_level_mv     <= cfg.data;
				bvlq_pkg::REG_RECOVERY_LEVEL: cfg_q.recovery_level_mv <= cfg.data;
				bvlq_pkg::REG_LOW_CONFIRM: begin
					cfg_q.low_confirm_needed <= cfg.data[bvlq_pkg::NEED_W-1:0];
				end
				bvlq_pkg::REG_VALID_CONFIRM: begin
					cfg_q.valid_confirm_needed <= cfg.data[bvlq_pkg::NEED_W-1:0];
				end
				bvlq_pkg::REG_RECOV_CONFIRM: begin
					cfg_q.recovery_confirm_needed <= cfg.data[bvlq_pkg::NEED_W-1:0];
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/bvlq_core.sv @@
// Battery voltage level qualifier: status register, confirm counters and their update.
// Depends on bvlq_pkg (status_t, cfg_t).
module bvlq_core #(
	parameter int COUNT_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         func,
	input  logic [bvlq_pkg::MV_W-1:0]    sample_mv,
	input  bvlq_pkg::cfg_t               cfg_q,
	output bvlq_pkg::status_t            status_q,
	output bvlq_pkg::status_t            status_nxt
);

	// Compare width covers both the counters and the needed counts
	localparam int CMP_W = (COUNT_BITS > bvlq_pkg::NEED_W) ? COUNT_BITS : bvlq_pkg::NEED_W;
	localparam logic [COUNT_BITS-1:0] RUN_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] safe_run_q, low_run_q, recovery_run_q;
	logic [COUNT_BITS-1:0] safe_run_nxt, low_run_nxt, recovery_run_nxt;

	function automatic logic [CMP_W-1:0] ext_run(input logic [COUNT_BITS-1:0] run);
		return CMP_W'(run);
	endfunction

	function automatic logic [CMP_W-1:0] ext_need(input logic [bvlq_pkg::NEED_W-1:0] need);
		return CMP_W'(need);
	endfunction

	// Saturating count toward a needed value
	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] run,
			input logic [bvlq_pkg::NEED_W-1:0] need);
		logic [COUNT_BITS-1:0] res;
		res = run;
		if (ext_run(run) < ext_need(need) && run != RUN_MAX) begin
			res = run + COUNT_BITS'(1);
		end
		return res;
	endfunction

	logic at_critical, at_trip, at_recovery;
	logic [COUNT_BITS-1:0] rec_bumped, low_cand, safe_cand;

	// Level comparisons
	assign at_critical = (sample_mv <= cfg_q.critical_level_mv);
	assign at_trip     = (sample_mv <= cfg_q.trip_level_mv);
	assign at_recovery = (sample_mv >= cfg_q.recovery_level_mv);

	// Next status and counters for the event at hand
	always_comb begin
		status_nxt       = status_q;
		safe_run_nxt     = safe_run_q;
		low_run_nxt      = low_run_q;
		recovery_run_nxt = recovery_run_q;
		rec_bumped       = bump(recovery_run_q, cfg_q.recovery_confirm_needed);
		low_cand         = low_run_q;
		safe_cand        = safe_run_q;
		if (func) begin
			// Invalidate: drop the runs, keep a latched low
			safe_run_nxt     = '0;
			low_run_nxt      = '0;
			recovery_run_nxt = '0;
			status_nxt = (status_q == bvlq_pkg::ST_LOW) ? bvlq_pkg::ST_LOW
			                                            : bvlq_pkg::ST_UNKNOWN;
		end else if (at_critical) begin
			status_nxt       = bvlq_pkg::ST_LOW;
			safe_run_nxt     = '0;
			low_run_nxt      = '0;
			recovery_run_nxt = '0;
		end else if (status_q == bvlq_pkg::ST_LOW) begin
			// Low: count recovery samples
			safe_run_nxt = '0;
			low_run_nxt  = '0;
			if (at_recovery) begin
				if (ext_run(rec_bumped) >= ext_need(cfg_q.recovery_confirm_needed)) begin
					status_nxt       = bvlq_pkg::ST_NORMAL;
					recovery_run_nxt = '0;
				end else begin
					recovery_run_nxt = rec_bumped;
				end
			end else begin
				recovery_run_nxt = '0;
			end
		end else begin
			// Unknown or normal: count trip samples, and safe samples while unknown
			recovery_run_nxt = '0;
			if (at_trip) begin
				safe_cand = '0;
				low_cand  = bump(low_run_q, cfg_q.low_confirm_needed);
			end else begin
				low_cand = '0;
				if (status_q == bvlq_pkg::ST_UNKNOWN) begin
					safe_cand = bump(safe_run_q, cfg_q.valid_confirm_needed);
				end
			end
			safe_run_nxt = safe_cand;
			low_run_nxt  = low_cand;
			if (ext_run(low_cand) >= ext_need(cfg_q.low_confirm_needed)) begin
				status_nxt  = bvlq_pkg::ST_LOW;
				low_run_nxt = '0;
			end else if (status_q == bvlq_pkg::ST_UNKNOWN &&
			             ext_run(safe_cand) >= ext_need(cfg_q.valid_confirm_needed)) begin
				status_nxt = bvlq_pkg::ST_NORMAL;
			end
		end
	end

	// Commit the state once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q       <= bvlq_pkg::ST_UNKNOWN;
			safe_run_q     <= '0;
			low_run_q      <= '0;
			recovery_run_q <= '0;
		end else if (step) begin
			status_q       <= status_nxt;
			safe_run_q     <= safe_run_nxt;
			low_run_q      <= low_run_nxt;
			recovery_run_q <= recovery_run_nxt;
		end
	end

endmodule

@@ rtl/battery_voltage_level_qualifier.sv @@
// Battery voltage level qualifier: top level with input and result registers.
// Depends on bvlq_pkg, bvlq_ifs (channel interfaces), bvlq_cfg_regs and bvlq_core.
//
//   channel  dir  payload                     transaction
//   evt      in   func, sample_mv             valid & ready
//   res      out  battery_status, is_low      valid & ready
//   cfg      in   index, data                 valid & ready (ready tied high)
//
// One event per cycle sustained while res is ready. The evt transaction loads
// the input register, and the status update then loads the result register,
// which raises res valid, once that register is free or being read. Reset
// clears status to unknown, the confirm counters to zero and the
// configuration to its defaults. A stalled result register holds its
// transaction; the input register still takes one more event behind it.
module battery_voltage_level_qualifier #(
	parameter int COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	bvlq_evt_if.sink   evt,
	bvlq_res_if.source res,
	bvlq_cfg_if.sink   cfg
);

	bvlq_pkg::cfg_t    cfg_q;
	bvlq_pkg::status_t status_q, status_nxt;

	logic                      evt_vld_s1;
	logic                      func_s1;
	logic [bvlq_pkg::MV_W-1:0] mv_s1;
	logic                      res_vld_s2;
	bvlq_pkg::status_t         status_s2;
	logic                      advance;

	bvlq_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	// Move the held event into the result register when it is free
	assign advance   = evt_vld_s1 && (!res_vld_s2 || res.ready);
	assign evt.ready = !evt_vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			evt_vld_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			func_s1 <= evt.func;
			mv_s1   <= evt.sample_mv;
		end
	end

	bvlq_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.func       (func_s1),
		.sample_mv  (mv_s1),
		.cfg_q      (cfg_q),
		.status_q   (status_q),
		.status_nxt (status_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (advance) begin
			res_vld_s2 <= 1'b1;
		end else if (res.ready) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_nxt;
		end
	end

	assign res.valid          = res_vld_s2;
	assign res.battery_status = status_s2;
	assign res.is_low         = (status_s2 == bvlq_pkg::ST_LOW);

	// The result shown is the status the core committed
	a_res_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res.valid && res.battery_status == status_q)
		else $error("result status differs from committed status");

	// A critical sample latches low
	a_critical_latches_low: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !func_s1 && mv_s1 <= cfg_q.critical_level_mv |=>
		status_q == bvlq_pkg::ST_LOW)
		else $error("critical sample did not latch low");

	// Invalidate never yields normal
	a_invalidate_no_normal: assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 |=> status_q != bvlq_pkg::ST_NORMAL)
		else $error("invalidate left status normal");

	// Low can only be left toward normal, and only through a sample
	a_low_exit: assert property (@(posedge clk) disable iff (!arst_n)
		status_q == bvlq_pkg::ST_LOW && !(advance && !func_s1) |=>
		status_q == bvlq_pkg::ST_LOW)
		else $error("low status left without a sample");

endmodule
